// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/wtf_pkg.sv =====
package wtf_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int PRIME_COUNT  = 3;
    localparam int SPOKE_COUNT  = 8;

    localparam int BIDX_W    = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
    localparam int GIDX_W    = (SPOKE_COUNT > 1) ? $clog2(SPOKE_COUNT) : 1;
    localparam int DIV_CNT_W = $clog2(NUMBER_WIDTH);

    localparam logic [7:0] BASIS_PRIMES [PRIME_COUNT] = '{8'd2, 8'd3, 8'd5};

    // wheel over basis 2,3,5: 7,11,13,17,19,23,29,31, last gap wraps to 37
    localparam logic [7:0] WHEEL_FIRST = 8'd7;
    localparam logic [7:0] WHEEL_GAPS [SPOKE_COUNT] =
        '{8'd4, 8'd2, 8'd4, 8'd2, 8'd4, 8'd6, 8'd2, 8'd6};

    typedef enum logic [2:0] {
        EMIT_LEAD,
        EMIT_INVALID,
        EMIT_PEND,
        EMIT_PEND_LAST,
        EMIT_REMAIN,
        EMIT_TEST
    } emit_sel_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_START  = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_EVAL   = 7'b0001000,
        ST_EMITP  = 7'b0010000,
        ST_FINAL  = 7'b0100000,
        ST_FINAL2 = 7'b1000000
    } state_t;

    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      take;
        logic      advance;
        logic      emit;
        emit_sel_t emit_sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic stop;
        logic n_zero;
        logic n_one;
        logic test_mode;
        logic pend_valid;
        logic cnt_one;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/wheel_trial_factorizer_top.sv =====
// Each trial division starts the restoring divider, then checks the remainder; basis primes
// first, then wheel candidates up to the square root of what is left. One number is taken
// at a time; worst case near 17500 wheel trials. Results leave through a one-beat output
// register; a new number is taken once the last beat is loaded there. Reset (rst_n, async,
// active low) empties the controller and the output register.
module wheel_trial_factorizer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              command,
    input  logic [wtf_pkg::NUMBER_WIDTH-1:0]  number,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [wtf_pkg::NUMBER_WIDTH-1:0]  factor_value,
    output logic                              prime_flag,
    output logic                              invalid,
    output logic                              last
);

    wtf_pkg::cmd_t    cmd;
    wtf_pkg::status_t status;

    wtf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (status),
        .c          (cmd)
    );

    wtf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .command      (command),
        .number       (number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .factor_value (factor_value),
        .prime_flag   (prime_flag),
        .invalid      (invalid),
        .last         (last)
    );

endmodule

// ===== hdl/wtf_div.sv =====
module wtf_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [wtf_pkg::NUMBER_WIDTH-1:0]  dividend,
    input  logic [wtf_pkg::NUMBER_WIDTH-1:0]  divisor,
    output logic                              done,
    output logic [wtf_pkg::NUMBER_WIDTH-1:0]  quotient,
    output logic [wtf_pkg::NUMBER_WIDTH-1:0]  remainder
);

    localparam int NW = wtf_pkg::NUMBER_WIDTH;
    localparam int CW = wtf_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dvs_reg;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[NW-1:0] : trial[NW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/wtf_datapath.sv =====
module wtf_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wtf_pkg::cmd_t                     cmd,
    output wtf_pkg::status_t                  status,
    input  logic                              command,
    input  logic [wtf_pkg::NUMBER_WIDTH-1:0]  number,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [wtf_pkg::NUMBER_WIDTH-1:0]  factor_value,
    output logic                              prime_flag,
    output logic                              invalid,
    output logic                              last
);

    localparam int NW = wtf_pkg::NUMBER_WIDTH;
    localparam int BW = wtf_pkg::BIDX_W;
    localparam int GW = wtf_pkg::GIDX_W;

    logic          mode_reg,       mode_next;
    logic [NW-1:0] n_reg,          n_next;
    logic [NW-1:0] k_reg,          k_next;
    logic          wheel_reg,      wheel_next;
    logic [BW-1:0] bidx_reg,       bidx_next;
    logic [GW-1:0] gidx_reg,       gidx_next;
    logic [NW-1:0] pend_reg,       pend_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [1:0]    cnt_reg,        cnt_next;

    logic          ovalid_reg;
    logic [NW-1:0] ofactor_reg;
    logic          oprime_reg;
    logic          oinvalid_reg;
    logic          olast_reg;

    logic [NW-1:0] e_factor;
    logic          e_prime;
    logic          e_invalid;
    logic          e_last;

    logic          div_done;
    logic [NW-1:0] quo;
    logic [NW-1:0] rem;
    logic          n_zero;
    logic          n_one;
    logic          out_free;

    assign n_zero   = (n_reg == '0);
    assign n_one    = (n_reg == NW'(1));
    assign out_free = !ovalid_reg || !result_stall;

    always_comb
    begin
        mode_next       = mode_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        wheel_next      = wheel_reg;
        bidx_next       = bidx_reg;
        gidx_next       = gidx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        if (cmd.load)
        begin
            mode_next       = command;
            n_next          = number;
            k_next          = NW'(wtf_pkg::BASIS_PRIMES[0]);
            wheel_next      = 1'b0;
            bidx_next       = '0;
            gidx_next       = '0;
            pend_valid_next = 1'b0;
            cnt_next        = 2'd0;
        end
        if (cmd.take)
        begin
            n_next          = quo;
            pend_next       = k_reg;
            pend_valid_next = 1'b1;
            if (cnt_reg != 2'd2)
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
        if (cmd.advance)
        begin
            if (wheel_reg)
            begin
                k_next    = k_reg + NW'(wtf_pkg::WHEEL_GAPS[gidx_reg]);
                gidx_next = (gidx_reg == GW'(wtf_pkg::SPOKE_COUNT - 1)) ?
                            '0 : gidx_reg + 1'b1;
            end
            else if (bidx_reg == BW'(wtf_pkg::PRIME_COUNT - 1))
            begin
                wheel_next = 1'b1;
                k_next     = NW'(wtf_pkg::WHEEL_FIRST);
            end
            else
            begin
                bidx_next = bidx_reg + 1'b1;
                k_next    = NW'(wtf_pkg::BASIS_PRIMES[bidx_reg + 1'b1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
            wheel_reg      <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            wheel_reg      <= wheel_next;
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        bidx_reg <= bidx_next;
        gidx_reg <= gidx_next;
        pend_reg <= pend_next;
        if (cmd.emit)
        begin
            ofactor_reg  <= e_factor;
            oprime_reg   <= e_prime;
            oinvalid_reg <= e_invalid;
            olast_reg    <= e_last;
        end
    end

    always_comb
    begin
        e_factor  = '0;
        e_prime   = 1'b0;
        e_invalid = 1'b0;
        e_last    = 1'b0;
        case (cmd.emit_sel)
            wtf_pkg::EMIT_LEAD:
            begin
                e_factor = NW'(1);
                e_last   = n_one;
            end
            wtf_pkg::EMIT_INVALID:
            begin
                e_invalid = 1'b1;
                e_last    = 1'b1;
            end
            wtf_pkg::EMIT_PEND:
            begin
                e_factor = pend_reg;
            end
            wtf_pkg::EMIT_PEND_LAST:
            begin
                e_factor = pend_reg;
                e_last   = 1'b1;
            end
            wtf_pkg::EMIT_REMAIN:
            begin
                e_factor = n_reg;
                e_last   = 1'b1;
            end
            wtf_pkg::EMIT_TEST:
            begin
                // prime iff exactly one factor counting a leftover above 1
                e_prime = ((cnt_reg == 2'd1) && n_one) ||
                          ((cnt_reg == 2'd0) && !n_one && !n_zero);
                e_last  = 1'b1;
            end
            default:
            begin
                e_factor = '0;
            end
        endcase
    end

    wtf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_next),
        .divisor   (k_next),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        status.div_done   = div_done;
        status.rem_zero   = (rem == '0);
        status.stop       = wheel_reg && (k_reg > quo);
        status.n_zero     = n_zero;
        status.n_one      = n_one;
        status.test_mode  = mode_reg;
        status.pend_valid = pend_valid_reg;
        status.cnt_one    = (cnt_reg == 2'd1);
        status.out_free   = out_free;
    end

    assign result_valid = ovalid_reg;
    assign factor_value = ofactor_reg;
    assign prime_flag   = oprime_reg;
    assign invalid      = oinvalid_reg;
    assign last         = olast_reg;

endmodule

// ===== hdl/wtf_ctrl.sv =====
`include "assert_macros.svh"

module wtf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  wtf_pkg::status_t st,
    output wtf_pkg::cmd_t    c
);

    wtf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        c.load      = 1'b0;
        c.div_start = 1'b0;
        c.take      = 1'b0;
        c.advance   = 1'b0;
        c.emit      = 1'b0;
        c.emit_sel  = wtf_pkg::EMIT_LEAD;
        case (state_reg)
            wtf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    c.load     = 1'b1;
                    state_next = wtf_pkg::ST_START;
                end
            end
            wtf_pkg::ST_START:
            begin
                if (st.test_mode)
                begin
                    if (st.n_zero || st.n_one)
                    begin
                        state_next = wtf_pkg::ST_FINAL;
                    end
                    else
                    begin
                        c.div_start = 1'b1;
                        state_next  = wtf_pkg::ST_DIV;
                    end
                end
                else if (st.out_free)
                begin
                    c.emit = 1'b1;
                    if (st.n_zero)
                    begin
                        c.emit_sel = wtf_pkg::EMIT_INVALID;
                        state_next = wtf_pkg::ST_IDLE;
                    end
                    else if (st.n_one)
                    begin
                        state_next = wtf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        c.div_start = 1'b1;
                        state_next  = wtf_pkg::ST_DIV;
                    end
                end
            end
            wtf_pkg::ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = wtf_pkg::ST_EVAL;
                end
            end
            wtf_pkg::ST_EVAL:
            begin
                if (st.stop)
                begin
                    state_next = wtf_pkg::ST_FINAL;
                end
                else if (st.rem_zero)
                begin
                    if (!st.test_mode && st.pend_valid)
                    begin
                        state_next = wtf_pkg::ST_EMITP;
                    end
                    else
                    begin
                        c.take = 1'b1;
                        if (st.test_mode && st.cnt_one)
                        begin
                            state_next = wtf_pkg::ST_FINAL;
                        end
                        else
                        begin
                            c.div_start = 1'b1;
                            state_next  = wtf_pkg::ST_DIV;
                        end
                    end
                end
                else
                begin
                    c.advance   = 1'b1;
                    c.div_start = 1'b1;
                    state_next  = wtf_pkg::ST_DIV;
                end
            end
            wtf_pkg::ST_EMITP:
            begin
                if (st.out_free)
                begin
                    c.emit      = 1'b1;
                    c.emit_sel  = wtf_pkg::EMIT_PEND;
                    c.take      = 1'b1;
                    c.div_start = 1'b1;
                    state_next  = wtf_pkg::ST_DIV;
                end
            end
            wtf_pkg::ST_FINAL:
            begin
                if (st.out_free)
                begin
                    c.emit     = 1'b1;
                    state_next = wtf_pkg::ST_IDLE;
                    if (st.test_mode)
                    begin
                        c.emit_sel = wtf_pkg::EMIT_TEST;
                    end
                    else if (!st.pend_valid)
                    begin
                        c.emit_sel = wtf_pkg::EMIT_REMAIN;
                    end
                    else if (st.n_one)
                    begin
                        c.emit_sel = wtf_pkg::EMIT_PEND_LAST;
                    end
                    else
                    begin
                        c.emit_sel = wtf_pkg::EMIT_PEND;
                        state_next = wtf_pkg::ST_FINAL2;
                    end
                end
            end
            wtf_pkg::ST_FINAL2:
            begin
                if (st.out_free)
                begin
                    c.emit     = 1'b1;
                    c.emit_sel = wtf_pkg::EMIT_REMAIN;
                    state_next = wtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wtf_pkg::ST_IDLE;
            end
        endcase
    end

    assign item_stall = (state_reg != wtf_pkg::ST_IDLE);

    `ASSERT_PROP(a_emit_needs_room, clk, rst_n, c.emit |-> st.out_free)
    `ASSERT_PROP(a_done_only_in_div, clk, rst_n, st.div_done |-> state_reg == wtf_pkg::ST_DIV)
    `ASSERT_NEVER(a_take_and_advance, clk, rst_n, c.take && c.advance)
    `ASSERT_PROP(a_start_after_load, clk, rst_n, c.load |=> state_reg == wtf_pkg::ST_START)

endmodule

// ===== sim/wheel_trial_factorizer_top_tb.sv =====
`timescale 1ns / 100ps

module wheel_trial_factorizer_top_tb;

    localparam logic CMD_FACTOR = 1'b0;
    localparam logic CMD_TEST   = 1'b1;

    localparam int  NUM_DIRECTED = 22;
    localparam int  NUM_RANDOM   = 78;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [wtf_pkg::NUMBER_WIDTH-1:0] factor_value;
        logic                             prime_flag;
        logic                             invalid;
        logic                             last;
    } factor_beat_t;

    typedef struct packed {
        logic                             cmd;
        logic [wtf_pkg::NUMBER_WIDTH-1:0] num;
        logic                             typed;
        factor_beat_t                     beat;
    } stim_row_t;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             item_valid   = 1'b0;
    logic                             item_stall;
    logic                             command      = 1'b0;
    logic [wtf_pkg::NUMBER_WIDTH-1:0] number       = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    logic [wtf_pkg::NUMBER_WIDTH-1:0] factor_value;
    logic                             prime_flag;
    logic                             invalid;
    logic                             last;

    factor_beat_t expected_beats[$];
    factor_beat_t seen_beat;
    int           mismatch_count = 0;
    longint       cycle_count    = 0;

    longint unsigned wheel_start;
    int              wheel_len;
    longint unsigned wheel_gap [wtf_pkg::SPOKE_COUNT];

    int   stall_left  = 0;
    logic stall_level = 1'b0;
    int   burst_left  = 0;

    // typed rows carry their single result beat; the rest go through the predictor
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        {CMD_FACTOR, 32'd0,          1'b1, 32'd0, 1'b0, 1'b1, 1'b1},
        {CMD_TEST,   32'd0,          1'b1, 32'd0, 1'b0, 1'b0, 1'b1},
        {CMD_TEST,   32'd1,          1'b1, 32'd0, 1'b0, 1'b0, 1'b1},
        {CMD_FACTOR, 32'd1,          1'b1, 32'd1, 1'b0, 1'b0, 1'b1},
        {CMD_TEST,   32'd2,          1'b1, 32'd0, 1'b1, 1'b0, 1'b1},
        {CMD_TEST,   32'd4,          1'b1, 32'd0, 1'b0, 1'b0, 1'b1},
        {CMD_FACTOR, 32'd2,          1'b0, 35'd0},
        {CMD_FACTOR, 32'd3,          1'b0, 35'd0},
        {CMD_FACTOR, 32'd5,          1'b0, 35'd0},
        {CMD_FACTOR, 32'd7,          1'b0, 35'd0},
        {CMD_FACTOR, 32'd30,         1'b0, 35'd0},
        {CMD_FACTOR, 32'd49,         1'b0, 35'd0},
        {CMD_FACTOR, 32'd37,         1'b0, 35'd0},
        {CMD_FACTOR, 32'd1517,       1'b0, 35'd0},
        {CMD_FACTOR, 32'd1052651,    1'b0, 35'd0},
        {CMD_FACTOR, 32'hFFFFFFFF,   1'b0, 35'd0},
        {CMD_FACTOR, 32'hFFFFFFFE,   1'b0, 35'd0},
        {CMD_FACTOR, 32'h80000000,   1'b0, 35'd0},
        {CMD_TEST,   32'd121,        1'b0, 35'd0},
        {CMD_TEST,   32'hFFFFFFFF,   1'b0, 35'd0},
        {CMD_TEST,   32'h80000000,   1'b0, 35'd0},
        {CMD_TEST,   32'd4294967291, 1'b0, 35'd0}
    };

    wheel_trial_factorizer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .number       (number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .factor_value (factor_value),
        .prime_flag   (prime_flag),
        .invalid      (invalid),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_factor_beats(input logic cmd,
                                                 input logic [wtf_pkg::NUMBER_WIDTH-1:0] num);
        longint unsigned rem;
        longint unsigned k;
        longint unsigned p;
        longint unsigned factors[$];
        int              g;
        factor_beat_t    beat;
        rem = 64'(num);
        if (cmd == CMD_FACTOR && num == 0)
        begin
            expected_beats.push_back({32'd0, 1'b0, 1'b1, 1'b1});
            return;
        end
        if (num > 1)
        begin
            for (int i = 0; i < wtf_pkg::PRIME_COUNT; i++)
            begin
                p = 64'(wtf_pkg::BASIS_PRIMES[i]);
                while (rem % p == 0)
                begin
                    factors.push_back(p);
                    rem = rem / p;
                end
            end
            k = wheel_start;
            g = 0;
            while (k <= rem / k)
            begin
                if (rem % k == 0)
                begin
                    factors.push_back(k);
                    rem = rem / k;
                end
                else
                begin
                    k = k + wheel_gap[g];
                    g = (g + 1 == wheel_len) ? 0 : g + 1;
                end
            end
            if (rem != 1)
                factors.push_back(rem);
        end
        if (cmd == CMD_TEST)
        begin
            expected_beats.push_back({32'd0, factors.size() == 1, 1'b0, 1'b1});
            return;
        end
        expected_beats.push_back({32'd1, 1'b0, 1'b0, factors.size() == 0});
        for (int i = 0; i < factors.size(); i++)
        begin
            beat.factor_value = factors[i][wtf_pkg::NUMBER_WIDTH-1:0];
            beat.prime_flag   = 1'b0;
            beat.invalid      = 1'b0;
            beat.last         = (i == factors.size() - 1);
            expected_beats.push_back(beat);
        end
    endfunction

    task automatic send_beat(input stim_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid = 1'b0;
                command    = 1'($urandom);
                number     = $urandom;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        item_valid = 1'b1;
        command    = row.cmd;
        number     = row.num;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (row.typed)
            expected_beats.push_back(row.beat);
        else
            predict_factor_beats(row.cmd, row.num);
    endtask

    function automatic logic [wtf_pkg::NUMBER_WIDTH-1:0] random_number();
        longint unsigned n;
        longint unsigned m;
        // small factors up to 255 times a 16-bit cofactor keep the trial loop short
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 300);
        n = 64'($urandom_range(1, 65535));
        while ($urandom_range(0, 5) != 0)
        begin
            m = 64'($urandom_range(2, 255));
            if (n * m > 64'hFFFFFFFF)
                break;
            n = n * m;
        end
        return n[wtf_pkg::NUMBER_WIDTH-1:0];
    endfunction

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_level = ($urandom_range(0, 2) == 0);
            stall_left  = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 20);
        end
        stall_left = stall_left - 1;
        result_stall <= stall_level;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: factor_value %0d", factor_value);
                mismatch_count++;
            end
            else
            begin
                seen_beat = expected_beats.pop_front();
                if (factor_value !== seen_beat.factor_value)
                begin
                    $error("factor_value: expected %0d, got %0d", seen_beat.factor_value,
                           factor_value);
                    mismatch_count++;
                end
                if (prime_flag !== seen_beat.prime_flag)
                begin
                    $error("prime_flag: expected %0d, got %0d", seen_beat.prime_flag, prime_flag);
                    mismatch_count++;
                end
                if (invalid !== seen_beat.invalid)
                begin
                    $error("invalid: expected %0d, got %0d", seen_beat.invalid, invalid);
                    mismatch_count++;
                end
                if (last !== seen_beat.last)
                begin
                    $error("last: expected %0d, got %0d", seen_beat.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        longint unsigned prod;
        longint unsigned prev;
        longint unsigned c;
        logic            coprime;
        stim_row_t       row;

        prod      = 1;
        prev      = 0;
        wheel_len = 0;
        wheel_start = 1;
        for (int i = 0; i < wtf_pkg::PRIME_COUNT; i++)
            prod = prod * 64'(wtf_pkg::BASIS_PRIMES[i]);
        for (int i = 0; i < wtf_pkg::SPOKE_COUNT; i++)
            wheel_gap[i] = 0;
        for (c = 64'(wtf_pkg::BASIS_PRIMES[wtf_pkg::PRIME_COUNT-1]);
             c < prod + 2 && wheel_len < wtf_pkg::SPOKE_COUNT; c++)
        begin
            coprime = 1'b1;
            for (int i = 0; i < wtf_pkg::PRIME_COUNT; i++)
                if (c % 64'(wtf_pkg::BASIS_PRIMES[i]) == 0)
                    coprime = 1'b0;
            if (coprime)
            begin
                if (wheel_len == 0)
                    wheel_start = c;
                else
                    wheel_gap[wheel_len-1] = c - prev;
                prev = c;
                wheel_len++;
            end
        end
        if (wheel_len == 0)
        begin
            wheel_start = prod + 1;
            wheel_len   = 1;
            prev        = wheel_start;
        end
        wheel_gap[wheel_len-1] = wheel_start + prod - prev;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_beat(directed_rows[i]);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            row.cmd   = ($urandom_range(0, 3) == 0) ? CMD_TEST : CMD_FACTOR;
            row.num   = random_number();
            row.typed = 1'b0;
            row.beat  = '0;
            send_beat(row);
        end

        @(negedge clk);
        item_valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
